// File: rtl/core/assert_macros.svh
// Assertion helpers used by area_interest_table_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, expr)
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/ait_pkg.sv
`timescale 1ns / 1ps
package ait_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int COORD_BITS  = 16;
  localparam int MAX_MATCHES = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 6;
  localparam int ID_W        = 32;
  localparam int REACH_W     = 8;
  localparam int UPD_W       = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int DIST_W      = COORD_BITS + 1;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_QUERY    = 2'd1,
    OP_FIND     = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_MATCH     = 3'd5,
    ST_DONE      = 3'd6
  } status_t;

  typedef enum logic {
    REG_CAPACITY  = 1'b0,
    REG_RECIPIENT = 1'b1
  } reg_sel_t;

  localparam int REG_SEL_BIT = 2;

  typedef struct packed {
    logic [ID_W-1:0]              id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [REACH_W-1:0]           reach;
    logic [UPD_W-1:0]             updates;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

// File: rtl/core/area_interest_table_top.sv
`timescale 1ns / 1ps
// Each transfer is scanned against the table one entry per cycle by a single comparator, except
// that a query holds on a match while the output is stalled. Register and find stop the scan at
// the first entry with the same node id. The input is ready again once the last result is loaded,
// so a new transfer is not taken before the last one is through.
// Reset clears the fill count and the output, and sets both limits to 32; entries are not cleared.
`include "assert_macros.svh"

module area_interest_table_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_opcode,
  input  logic [ait_pkg::ID_W-1:0]              in_node_id,
  input  logic signed [ait_pkg::COORD_BITS-1:0] in_cell_x,
  input  logic signed [ait_pkg::COORD_BITS-1:0] in_cell_y,
  input  logic [ait_pkg::REACH_W-1:0]           in_reach,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            out_status,
  output logic [ait_pkg::ID_W-1:0]              out_match_id,
  output logic signed [ait_pkg::COORD_BITS-1:0] out_match_x,
  output logic signed [ait_pkg::COORD_BITS-1:0] out_match_y,
  output logic [ait_pkg::REACH_W-1:0]           out_match_reach,
  output logic [ait_pkg::UPD_W-1:0]             out_update_count,
  output logic [ait_pkg::CNT_W-1:0]             out_entry_count,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ait_pkg::ADDR_W-1:0]            paddr,
  input  logic [ait_pkg::DATA_W-1:0]            pwdata,
  output logic [ait_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  ait_pkg::state_t                       state_r, state_nxt;
  ait_pkg::entry_t                       tbl_r [ait_pkg::TABLE_DEPTH];
  logic [ait_pkg::CNT_W-1:0]             fill_r, fill_nxt;
  logic [ait_pkg::CNT_W-1:0]             cap_r, cap_nxt;
  logic [ait_pkg::CNT_W-1:0]             limit_r, limit_nxt;
  logic [ait_pkg::CNT_W-1:0]             idx_r, idx_nxt;
  logic [ait_pkg::CNT_W-1:0]             nmatch_r, nmatch_nxt;
  logic [ait_pkg::IDX_W-1:0]             slot_r, slot_nxt;
  logic                                  found_r, found_nxt;
  logic [1:0]                            op_r, op_nxt;
  logic [ait_pkg::ID_W-1:0]              qid_r, qid_nxt;
  logic signed [ait_pkg::COORD_BITS-1:0] qx_r, qx_nxt;
  logic signed [ait_pkg::COORD_BITS-1:0] qy_r, qy_nxt;
  logic [ait_pkg::REACH_W-1:0]           qreach_r, qreach_nxt;

  logic                                  out_valid_r, out_valid_nxt;
  ait_pkg::status_t                      out_status_r, out_status_nxt;
  ait_pkg::entry_t                       out_entry_r, out_entry_nxt;
  logic [ait_pkg::CNT_W-1:0]             out_count_r, out_count_nxt;
  logic                                  out_last_r, out_last_nxt;

  logic                                  out_free;
  logic                                  out_load;
  logic                                  in_take;
  logic                                  cfg_wr;
  logic [ait_pkg::IDX_W-1:0]             rd_idx;
  ait_pkg::entry_t                       rd_entry;
  logic                                  wr_en;
  logic [ait_pkg::IDX_W-1:0]             wr_idx;
  ait_pkg::entry_t                       wr_entry;
  logic signed [ait_pkg::DIST_W-1:0]     dx, dy;
  logic [ait_pkg::DIST_W-1:0]            adx, ady;
  logic                                  covered;
  logic [ait_pkg::CNT_W-1:0]             cap_eff;
  logic [ait_pkg::CNT_W-1:0]             nmatch_inc;
  logic [ait_pkg::UPD_W-1:0]             upd_sat;

  assign in_stall  = (state_r != ait_pkg::S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_match_id     = out_entry_r.id;
  assign out_match_x      = out_entry_r.x;
  assign out_match_y      = out_entry_r.y;
  assign out_match_reach  = out_entry_r.reach;
  assign out_update_count = out_entry_r.updates;
  assign out_entry_count  = out_count_r;
  assign out_last         = out_last_r;

  always_comb begin
    case (ait_pkg::reg_sel_t'(paddr[ait_pkg::REG_SEL_BIT]))
      ait_pkg::REG_CAPACITY:  prdata = ait_pkg::DATA_W'(cap_r);
      ait_pkg::REG_RECIPIENT: prdata = ait_pkg::DATA_W'(limit_r);
      default:                prdata = '0;
    endcase
  end

  assign rd_idx   = (state_r == ait_pkg::S_FIN) ? slot_r : idx_r[ait_pkg::IDX_W-1:0];
  assign rd_entry = tbl_r[rd_idx];

  // The one compare unit: sender match and square coverage for the entry under the scan pointer.
  assign dx  = {qx_r[ait_pkg::COORD_BITS-1], qx_r} - {rd_entry.x[ait_pkg::COORD_BITS-1], rd_entry.x};
  assign dy  = {qy_r[ait_pkg::COORD_BITS-1], qy_r} - {rd_entry.y[ait_pkg::COORD_BITS-1], rd_entry.y};
  assign adx = dx[ait_pkg::DIST_W-1] ? ait_pkg::DIST_W'(-dx) : ait_pkg::DIST_W'(dx);
  assign ady = dy[ait_pkg::DIST_W-1] ? ait_pkg::DIST_W'(-dy) : ait_pkg::DIST_W'(dy);
  assign covered = (adx <= ait_pkg::DIST_W'(rd_entry.reach)) &&
                   (ady <= ait_pkg::DIST_W'(rd_entry.reach));

  assign cap_eff    = (cap_r > ait_pkg::CNT_W'(ait_pkg::TABLE_DEPTH)) ?
                      ait_pkg::CNT_W'(ait_pkg::TABLE_DEPTH) : cap_r;
  assign nmatch_inc = nmatch_r + 1'b1;
  assign upd_sat    = (&rd_entry.updates) ? rd_entry.updates : rd_entry.updates + 1'b1;

  always_comb begin
    cap_nxt   = cap_r;
    limit_nxt = limit_r;
    if (cfg_wr) begin
      case (ait_pkg::reg_sel_t'(paddr[ait_pkg::REG_SEL_BIT]))
        ait_pkg::REG_CAPACITY:  cap_nxt   = pwdata[ait_pkg::CNT_W-1:0];
        ait_pkg::REG_RECIPIENT: limit_nxt = pwdata[ait_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    nmatch_nxt     = nmatch_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    op_nxt         = op_r;
    qid_nxt        = qid_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    qreach_nxt     = qreach_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_idx         = slot_r;
    wr_entry       = rd_entry;

    case (state_r)
      ait_pkg::S_IDLE: begin
        if (in_take && (in_opcode inside {ait_pkg::OP_REGISTER, ait_pkg::OP_QUERY,
                                          ait_pkg::OP_FIND})) begin
          op_nxt     = in_opcode;
          qid_nxt    = in_node_id;
          qx_nxt     = in_cell_x;
          qy_nxt     = in_cell_y;
          qreach_nxt = in_reach;
          idx_nxt    = '0;
          nmatch_nxt = '0;
          found_nxt  = 1'b0;
          state_nxt  = ait_pkg::S_SCAN;
        end
      end

      ait_pkg::S_SCAN: begin
        if (idx_r >= fill_r) begin
          state_nxt = ait_pkg::S_FIN;
        end else if (op_r == ait_pkg::OP_QUERY) begin
          if (rd_entry.id != qid_r && covered) begin
            if (out_free) begin
              out_load       = 1'b1;
              out_status_nxt = ait_pkg::ST_MATCH;
              out_entry_nxt  = rd_entry;
              out_count_nxt  = fill_r;
              out_last_nxt   = 1'b0;
              nmatch_nxt     = nmatch_inc;
              if (nmatch_inc >= limit_r ||
                  nmatch_inc >= ait_pkg::CNT_W'(ait_pkg::MAX_MATCHES)) begin
                state_nxt = ait_pkg::S_FIN;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (rd_entry.id == qid_r) begin
          found_nxt = 1'b1;
          slot_nxt  = idx_r[ait_pkg::IDX_W-1:0];
          state_nxt = ait_pkg::S_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      ait_pkg::S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_last_nxt  = 1'b1;
          out_entry_nxt = '0;
          out_count_nxt = fill_r;
          state_nxt     = ait_pkg::S_IDLE;
          case (op_r)
            ait_pkg::OP_QUERY: begin
              out_status_nxt = ait_pkg::ST_DONE;
            end
            ait_pkg::OP_FIND: begin
              if (found_r) begin
                out_status_nxt = ait_pkg::ST_FOUND;
                out_entry_nxt  = rd_entry;
              end else begin
                out_status_nxt = ait_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              if (found_r) begin
                wr_en            = 1'b1;
                wr_idx           = slot_r;
                wr_entry.id      = rd_entry.id;
                wr_entry.x       = qx_r;
                wr_entry.y       = qy_r;
                wr_entry.reach   = qreach_r;
                wr_entry.updates = upd_sat;
                out_status_nxt   = ait_pkg::ST_UPDATED;
                out_entry_nxt    = wr_entry;
              end else if (fill_r >= cap_eff) begin
                out_status_nxt = ait_pkg::ST_FULL;
              end else begin
                wr_en            = 1'b1;
                wr_idx           = fill_r[ait_pkg::IDX_W-1:0];
                wr_entry.id      = qid_r;
                wr_entry.x       = qx_r;
                wr_entry.y       = qy_r;
                wr_entry.reach   = qreach_r;
                wr_entry.updates = ait_pkg::UPD_W'(1);
                fill_nxt         = fill_r + 1'b1;
                out_status_nxt   = ait_pkg::ST_INSERTED;
                out_entry_nxt    = wr_entry;
                out_count_nxt    = fill_r + 1'b1;
              end
            end
          endcase
        end
      end

      default: begin
        state_nxt = ait_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ait_pkg::S_IDLE;
      fill_r      <= '0;
      cap_r       <= ait_pkg::CNT_W'(32);
      limit_r     <= ait_pkg::CNT_W'(32);
      idx_r       <= '0;
      nmatch_r    <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      limit_r     <= limit_nxt;
      idx_r       <= idx_nxt;
      nmatch_r    <= nmatch_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    op_r         <= op_nxt;
    qid_r        <= qid_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    qreach_r     <= qreach_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    if (wr_en) begin
      tbl_r[wr_idx] <= wr_entry;
    end
  end

  `AST_ALWAYS(a_fill_bound, fill_r <= ait_pkg::CNT_W'(ait_pkg::TABLE_DEPTH))
  `AST_ALWAYS(a_no_overwrite, !(out_load && out_valid_r && out_stall))
  `AST_NEXT(a_fill_only_on_result, !out_load, $stable(fill_r))
  `AST_IMPLY(a_match_not_last, out_valid_r && out_status_r == ait_pkg::ST_MATCH, !out_last_r)
  `AST_ALWAYS(a_match_bound, nmatch_r <= ait_pkg::CNT_W'(ait_pkg::MAX_MATCHES))

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ait_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;
  localparam int ID_POOL_SIZE = 40;

  typedef struct {
    status_t                      status;
    logic [ID_W-1:0]              id;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [REACH_W-1:0]           reach;
    logic [UPD_W-1:0]             updates;
    logic [CNT_W-1:0]             held;
    logic                         last;
  } interest_note_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   in_opcode;
  logic [ID_W-1:0]              in_node_id;
  logic signed [COORD_BITS-1:0] in_cell_x;
  logic signed [COORD_BITS-1:0] in_cell_y;
  logic [REACH_W-1:0]           in_reach;
  logic                         out_valid;
  logic                         out_stall;
  logic [2:0]                   out_status;
  logic [ID_W-1:0]              out_match_id;
  logic signed [COORD_BITS-1:0] out_match_x;
  logic signed [COORD_BITS-1:0] out_match_y;
  logic [REACH_W-1:0]           out_match_reach;
  logic [UPD_W-1:0]             out_update_count;
  logic [CNT_W-1:0]             out_entry_count;
  logic                         out_last;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ADDR_W-1:0]            paddr;
  logic [DATA_W-1:0]            pwdata;
  logic [DATA_W-1:0]            prdata;
  logic                         pready;

  entry_t         interest_tbl[TABLE_DEPTH];
  int unsigned    entries_held;
  logic [CNT_W-1:0] capacity_reg;
  logic [CNT_W-1:0] recipient_reg;
  interest_note_t expected_notices[$];
  interest_note_t due_note;
  logic [ID_W-1:0] id_pool[ID_POOL_SIZE];

  int  errors;
  int  transfers_in;
  int  queries_in;
  int  notices_checked;
  int  matches_seen;
  int  fulls_seen;
  int  hold_request;
  bit  steady;

  area_interest_table_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (steady || $urandom_range(0, 99) < 75) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = idle_len();
        if (stall_left > 0) stall_left--;
        out_stall <= 1'b1;
      end
    end
  end

  function automatic void push_notice(status_t st, int slot, bit last);
    interest_note_t n;
    n = '{status: st, id: '0, x: '0, y: '0, reach: '0, updates: '0,
          held: entries_held[CNT_W-1:0], last: last};
    if (slot >= 0) begin
      n.id = interest_tbl[slot].id;
      n.x = interest_tbl[slot].x;
      n.y = interest_tbl[slot].y;
      n.reach = interest_tbl[slot].reach;
      n.updates = interest_tbl[slot].updates;
    end
    expected_notices = {expected_notices, n};
  endfunction

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < entries_held; i++)
      if (interest_tbl[i].id == id) return i;
    return -1;
  endfunction

  function automatic void apply_interest_op(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic signed [COORD_BITS-1:0] cx,
                                            logic signed [COORD_BITS-1:0] cy,
                                            logic [REACH_W-1:0] reach);
    int slot;
    int cap;
    int found;
    int dx;
    int dy;
    slot = slot_of(id);
    cap = (capacity_reg < TABLE_DEPTH) ? capacity_reg : TABLE_DEPTH;
    case (op)
      OP_REGISTER: begin
        if (slot >= 0) begin
          interest_tbl[slot].x = cx;
          interest_tbl[slot].y = cy;
          interest_tbl[slot].reach = reach;
          if (interest_tbl[slot].updates != '1)
            interest_tbl[slot].updates = interest_tbl[slot].updates + 1;
          push_notice(ST_UPDATED, slot, 1'b1);
        end else if (entries_held >= cap) begin
          push_notice(ST_FULL, -1, 1'b1);
        end else begin
          interest_tbl[entries_held] = '{id: id, x: cx, y: cy, reach: reach, updates: 1};
          entries_held++;
          push_notice(ST_INSERTED, entries_held - 1, 1'b1);
        end
      end
      OP_QUERY: begin
        found = 0;
        for (int i = 0; i < entries_held; i++) begin
          if (interest_tbl[i].id == id) continue;
          dx = int'(cx) - int'(interest_tbl[i].x);
          dy = int'(cy) - int'(interest_tbl[i].y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx > interest_tbl[i].reach || dy > interest_tbl[i].reach) continue;
          push_notice(ST_MATCH, i, 1'b0);
          found++;
          if (found >= recipient_reg || found >= MAX_MATCHES) break;
        end
        push_notice(ST_DONE, -1, 1'b1);
      end
      OP_FIND: begin
        if (slot >= 0) push_notice(ST_FOUND, slot, 1'b1);
        else push_notice(ST_NOT_FOUND, -1, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_notices.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: unexpected result transfer, expected none, actual status %0d",
                   $time, out_status);
      end else begin
        due_note = expected_notices.pop_front();
        check_field("status", due_note.status, out_status);
        check_field("match_id", due_note.id, out_match_id);
        check_field("match_x", due_note.x, out_match_x);
        check_field("match_y", due_note.y, out_match_y);
        check_field("match_reach", due_note.reach, out_match_reach);
        check_field("update_count", due_note.updates, out_update_count);
        check_field("entry_count", due_note.held, out_entry_count);
        check_field("last", due_note.last, out_last);
        notices_checked++;
        if (due_note.status == ST_MATCH) matches_seen++;
        if (due_note.status == ST_FULL) fulls_seen++;
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] id,
                           input logic signed [COORD_BITS-1:0] cx,
                           input logic signed [COORD_BITS-1:0] cy,
                           input logic [REACH_W-1:0] reach);
    int gap;
    gap = steady ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_node_id <= id;
    in_cell_x <= cx;
    in_cell_y <= cy;
    in_reach <= reach;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_interest_op(op, id, cx, cy, reach);
    if (op != OP_UNUSED) transfers_in++;
    if (op == OP_QUERY) queries_in++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_notices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_sel_t sel, input logic [CNT_W-1:0] value);
    logic [ADDR_W-1:0] addr;
    addr = '0;
    addr[REG_SEL_BIT] = sel;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_CAPACITY) capacity_reg = value;
    else recipient_reg = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("register readback", DATA_W'(value), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_op(output bit counted);
    logic [1:0] op;
    logic [ID_W-1:0] id;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [REACH_W-1:0] reach;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_REGISTER;
    else if (r < 75) op = OP_QUERY;
    else if (r < 95) op = OP_FIND;
    else op = OP_UNUSED;
    if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    else id = $urandom();
    if ($urandom_range(0, 99) < 80) begin
      cx = COORD_BITS'($urandom_range(0, 48) - 24);
      cy = COORD_BITS'($urandom_range(0, 48) - 24);
    end else begin
      cx = COORD_BITS'($urandom_range(0, 65535));
      cy = COORD_BITS'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 99) < 80) reach = REACH_W'($urandom_range(0, 24));
    else reach = REACH_W'($urandom_range(0, 255));
    send_item(op, id, cx, cy, reach);
    counted = (op != OP_UNUSED);
  endtask

  task automatic test_empty_table();
    send_item(OP_FIND, 32'h0, 16'sd0, 16'sd0, 8'd0);
    send_item(OP_QUERY, 32'h1, 16'sd0, 16'sd0, 8'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, -16'sd1, -16'sd1, 8'hFF);
    send_item(OP_FIND, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_zero_capacity();
    cfg_write(REG_CAPACITY, 6'd0);
    send_item(OP_REGISTER, 32'h7, 16'sd3, 16'sd4, 8'd5);
    send_item(OP_FIND, 32'h7, 16'sd0, 16'sd0, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_small_capacity();
    cfg_write(REG_CAPACITY, 6'd3);
    send_item(OP_REGISTER, 32'h0, -16'sd32768, 16'sd32767, 8'hFF);
    send_item(OP_REGISTER, 32'hFFFF_FFFF, 16'sd32767, -16'sd32768, 8'h00);
    send_item(OP_REGISTER, 32'h5A5A_A5A5, 16'sd0, 16'sd0, 8'd1);
    send_item(OP_REGISTER, 32'h1234_5678, 16'sd0, 16'sd0, 8'd1);
    send_item(OP_REGISTER, 32'h0, -16'sd32768, 16'sd32767, 8'hFF);
    send_item(OP_FIND, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 8'd0);
    send_item(OP_FIND, 32'h1234_5678, 16'sd0, 16'sd0, 8'd0);
    send_item(OP_QUERY, 32'h0, 16'sd32767, -16'sd32768, 8'd0);
    send_item(OP_QUERY, 32'h1, -16'sd32513, 16'sd32512, 8'd0);
    send_item(OP_QUERY, 32'h3, 16'sd1, -16'sd1, 8'd0);
    send_item(OP_QUERY, 32'hFFFF_FFFF, -16'sd32768, 16'sd32767, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_recipient_limit();
    cfg_write(REG_CAPACITY, 6'd6);
    send_item(OP_REGISTER, 32'h0F0F_0F0F, 16'sd1, 16'sd1, 8'd2);
    wait_results_drained();
    cfg_write(REG_RECIPIENT, 6'd0);
    send_item(OP_QUERY, 32'h9, 16'sd0, 16'sd0, 8'd0);
    wait_results_drained();
    cfg_write(REG_RECIPIENT, 6'd1);
    send_item(OP_QUERY, 32'h9, 16'sd0, 16'sd0, 8'd0);
    wait_results_drained();
    cfg_write(REG_RECIPIENT, 6'd63);
    send_item(OP_QUERY, 32'h9, 16'sd0, 16'sd0, 8'd0);
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int count, input logic [CNT_W-1:0] cap,
                                     input logic [CNT_W-1:0] rcpt);
    int sent;
    bit counted;
    cfg_write(REG_CAPACITY, cap);
    cfg_write(REG_RECIPIENT, rcpt);
    sent = 0;
    while (sent < count) begin
      if (sent % 16 == 0) steady = ($urandom_range(0, 2) == 0);
      send_random_op(counted);
      if (counted) sent++;
    end
    steady = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    bit counted;
    steady = 1'b1;
    hold_request = 200;
    repeat (12) send_random_op(counted);
    steady = 1'b0;
    wait_results_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = '0;
    in_node_id = '0;
    in_cell_x = '0;
    in_cell_y = '0;
    in_reach = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    transfers_in = 0;
    queries_in = 0;
    notices_checked = 0;
    matches_seen = 0;
    fulls_seen = 0;
    hold_request = 0;
    steady = 1'b0;
    entries_held = 0;
    capacity_reg = 6'd32;
    recipient_reg = 6'd32;
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h5A5A_A5A5;
    id_pool[3] = 32'h0F0F_0F0F;
    for (int i = 4; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_zero_capacity();
    test_small_capacity();
    test_recipient_limit();
    test_random_traffic(45, 6'd20, 6'd5);
    test_random_traffic(40, 6'd63, 6'd1);
    test_output_backpressure();
    test_random_traffic(45, 6'd32, 6'd63);
    test_random_traffic(30, 6'd17, 6'd32);

    wait_results_drained();
    $display("Covered %0d input transfers (%0d queries) and %0d checked results,",
             transfers_in, queries_in, notices_checked);
    $display("including %0d matches, %0d full replies, limits from 0 to 63 and back-pressure.",
             matches_seen, fulls_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
